// ===== hw/rtl/utf8_sanitizer_unit_defines.svh =====
// Assertion macros shared by the UTF-8 sanitizer RTL.
`ifndef UTF8_SANITIZER_UNIT_DEFINES_SVH
`define UTF8_SANITIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define U8S_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8 sanitizer check failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define U8S_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8 sanitizer check failed");
`else
`define U8S_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define U8S_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ===== hw/rtl/u8s_pkg.sv =====
// Types and constants shared by the UTF-8 sanitizer modules.
`timescale 1ns / 1ps
`default_nettype none

package u8s_pkg;

   // Replacement character for invalid input.
   localparam logic [7:0] QMARK = 8'h3F;

   // Most beats one input byte can cause.
   localparam int SLOTS = 4;

   // Default number of bundles the queue holds.
   localparam int QUEUE_DEPTH = 4;

   // All result beats caused by one input byte.
   typedef struct packed {
      logic [SLOTS-1:0][7:0] bytes;
      logic [SLOTS-1:0]      rep;
      logic [2:0]            count;
      logic                  last;
   } bundle_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic [1:0] held;
      logic [1:0] need;
   } front_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/u8s_req_if.sv =====
// Input byte channel of the UTF-8 sanitizer.
`timescale 1ns / 1ps
`default_nettype none

interface u8s_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8s_rsp_if.sv =====
// Result byte channel of the UTF-8 sanitizer.
`timescale 1ns / 1ps
`default_nettype none

interface u8s_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_replaced;
   logic       out_last;

   modport source (output valid, output out_byte, output out_replaced, output out_last,
                   input ready);
   modport sink (input valid, input out_byte, input out_replaced, input out_last,
                 output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/u8s_front.sv =====
// Front end: classifies each byte, tracks the open sequence and builds result bundles.
`timescale 1ns / 1ps
`default_nettype none

module u8s_front (
   input  logic                    clock,
   input  logic                    reset,
   u8s_req_if.sink                 req,
   input  u8s_pkg::queue_stat_type q_stat,
   output logic                    push_valid,
   output u8s_pkg::bundle_type     push_data,
   output u8s_pkg::front_stat_type stat
);

   logic [2:0][7:0] held_ff, held_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      need_ff, need_in;

   logic            fire;
   logic [7:0]      b;
   logic            last;
   logic            is_open, is_cont, is_ascii, is_lead;
   logic [1:0]      lead_need;
   logic            complete, extend;
   logic [1:0]      pre;
   logic [3:0][7:0] held_ext;

   always_comb begin
      req.ready = !q_stat.full;
      fire      = req.valid && !q_stat.full;
      b         = req.in_byte;
      last      = req.in_last;
      is_open   = cnt_ff != 2'd0;
      is_cont   = b[7:6] == 2'b10;
      is_ascii  = !b[7];

      priority if (b[7:5] == 3'b110) begin
         lead_need = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         lead_need = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         lead_need = 2'd3;
      end else begin
         lead_need = 2'd0;
      end
      is_lead = lead_need != 2'd0;

      complete = is_open && is_cont && (cnt_ff >= need_ff);
      extend   = is_open && is_cont && !complete;
      pre      = is_open ? cnt_ff : 2'd0;
      held_ext = {b, held_ff};

      push_data.last = last;
      held_in        = held_ff;

      if (complete) begin
         // The sequence is whole: held bytes go out, then this byte.
         for (int i = 0; i < u8s_pkg::SLOTS; i++) begin
            push_data.bytes[i] = (3'(i) < {1'b0, cnt_ff}) ? held_ext[i] : b;
            push_data.rep[i]   = 1'b0;
         end
         push_data.count = {1'b0, cnt_ff} + 3'd1;
         cnt_in          = 2'd0;
         need_in         = 2'd0;
      end else if (extend) begin
         // Another continuation is held; a string end flushes everything as '?'.
         for (int i = 0; i < u8s_pkg::SLOTS; i++) begin
            push_data.bytes[i] = u8s_pkg::QMARK;
            push_data.rep[i]   = 1'b1;
         end
         for (int k = 0; k < 3; k++) begin
            if (2'(k) == cnt_ff) begin
               held_in[k] = b;
            end
         end
         push_data.count = last ? ({1'b0, cnt_ff} + 3'd1) : 3'd0;
         cnt_in          = last ? 2'd0 : (cnt_ff + 2'd1);
         need_in         = last ? 2'd0 : need_ff;
      end else begin
         // Interrupted sequence (if any) flushes as '?', then the byte starts afresh.
         for (int i = 0; i < u8s_pkg::SLOTS; i++) begin
            if (3'(i) < {1'b0, pre}) begin
               push_data.bytes[i] = u8s_pkg::QMARK;
               push_data.rep[i]   = 1'b1;
            end else begin
               push_data.bytes[i] = is_ascii ? b : u8s_pkg::QMARK;
               push_data.rep[i]   = !is_ascii;
            end
         end
         push_data.count = {1'b0, pre} + ((is_lead && !last) ? 3'd0 : 3'd1);
         if (is_lead && !last) begin
            held_in[0] = b;
            cnt_in     = 2'd1;
            need_in    = lead_need;
         end else begin
            cnt_in  = 2'd0;
            need_in = 2'd0;
         end
      end

      push_valid = fire && (push_data.count != 3'd0);
      stat.held  = cnt_ff;
      stat.need  = need_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= 2'd0;
         need_ff <= 2'd0;
      end else if (fire) begin
         cnt_ff  <= cnt_in;
         need_ff <= need_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         held_ff <= held_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/u8s_queue.sv =====
// Bundle queue between the front end and the output serializer.
`timescale 1ns / 1ps
`default_nettype none

module u8s_queue #(
   parameter int DEPTH = u8s_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  u8s_pkg::bundle_type     push_data,
   input  logic                    pop,
   output u8s_pkg::bundle_type     head,
   output u8s_pkg::queue_stat_type stat
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   u8s_pkg::bundle_type store_ff [DEPTH];
   logic [AW-1:0]       wr_ff, wr_in;
   logic [AW-1:0]       rd_ff, rd_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                do_push, do_pop;

   always_comb begin
      stat.full  = cnt_ff == CW'(DEPTH);
      stat.empty = cnt_ff == '0;
      do_push    = push_valid && !stat.full;
      do_pop     = pop && !stat.empty;
      head       = store_ff[rd_ff];

      wr_in = wr_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : (wr_ff + AW'(1));
      end
      rd_in = rd_ff;
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : (rd_ff + AW'(1));
      end
      unique case ({do_push, do_pop})
         2'b10:   cnt_in = cnt_ff + CW'(1);
         2'b01:   cnt_in = cnt_ff - CW'(1);
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/u8s_back.sv =====
// Back end: sends each bundle's beats from an output register, one per ready cycle.
`timescale 1ns / 1ps
`default_nettype none

module u8s_back (
   input  logic                    clock,
   input  logic                    reset,
   u8s_rsp_if.source               rsp,
   input  u8s_pkg::bundle_type     q_head,
   input  u8s_pkg::queue_stat_type q_stat,
   output logic                    pop
);

   u8s_pkg::bundle_type cur_ff;
   logic                live_ff;
   logic [1:0]          idx_ff;
   logic                beat, at_end, free;

   always_comb begin
      beat   = live_ff && rsp.ready;
      at_end = {1'b0, idx_ff} == (cur_ff.count - 3'd1);
      free   = !live_ff || (beat && at_end);
      pop    = free && !q_stat.empty;

      rsp.valid        = live_ff;
      rsp.out_byte     = cur_ff.bytes[idx_ff];
      rsp.out_replaced = cur_ff.rep[idx_ff];
      rsp.out_last     = cur_ff.last && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else if (free) begin
         live_ff <= !q_stat.empty;
         idx_ff  <= 2'd0;
      end else if (beat) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= q_head;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/utf8_sanitizer_unit.sv =====
// With the output side idle, a byte's bundle goes into the queue and then into the
// output register, which drives the first result beat as soon as it is loaded.
// Throughput: one byte per cycle while each byte gives at most one result beat and the
// result side takes a beat every cycle.
// A byte completing or breaking a sequence gives up to four beats, one per ready cycle.
// Reset is synchronous: the open sequence, the queue and the output register are cleared.
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_sanitizer_unit_defines.svh"

// Streaming UTF-8 repair. The front end looks at every accepted byte together with
// the sequence it may be holding (lead byte plus continuations) and decides, in the
// same cycle, all result beats that byte causes. Those beats travel as one bundle
// through a short queue, so the front end keeps accepting bytes while the back end
// is still sending a long burst, and a stall on the result side does not reach the
// input side until the queue is full.
module utf8_sanitizer_unit #(
   parameter int QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   u8s_req_if.sink   req_bus,
   u8s_rsp_if.source rsp_bus
);

   logic                    push_valid;
   u8s_pkg::bundle_type     push_data;
   u8s_pkg::bundle_type     q_head;
   u8s_pkg::queue_stat_type q_stat;
   u8s_pkg::front_stat_type f_stat;
   logic                    pop;
   logic                    in_last_beat;

   // Classification and sequence tracking. A beat is taken whenever the queue has room.
   u8s_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_data  (push_data),
      .stat       (f_stat)
   );

   // Bundles that wait for the output side. Bytes that cause no beat never enter it.
   u8s_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (q_head),
      .stat       (q_stat)
   );

   // Serializer. The next bundle is loaded in the same cycle the last beat of the
   // current one is taken, so back-to-back bundles leave without a gap.
   u8s_back u_back (
      .clock  (clock),
      .reset  (reset),
      .rsp    (rsp_bus),
      .q_head (q_head),
      .q_stat (q_stat),
      .pop    (pop)
   );

   // The final byte of a string is being taken in this cycle.
   assign in_last_beat = req_bus.valid && req_bus.ready && req_bus.in_last;

   // An open sequence never holds more bytes than its lead byte asks for.
   `U8S_ASSERT_SAME(a_held_within_need, clock, reset, f_stat.held != 2'd0, f_stat.held <= f_stat.need)
   // The end of a string always closes any open sequence.
   `U8S_ASSERT_NEXT(a_last_closes, clock, reset, in_last_beat, f_stat.held == 2'd0)
   // An idle serializer picks up a waiting bundle in the next cycle.
   `U8S_ASSERT_NEXT(a_back_picks_up, clock, reset, !rsp_bus.valid && !q_stat.empty, rsp_bus.valid)

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Self-checking testbench for the streaming UTF-8 sanitizer.
`timescale 1ns / 1ps

module tb_top;

   // Byte classes of UTF-8. A byte belongs to a class when (byte & mask) == tag.
   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_TAG   = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_TAG  = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_TAG  = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_TAG  = 8'hF0;
   localparam logic [7:0] ASCII_TOP  = 8'h7F;

   localparam int RANDOM_BYTES = 420;

   // One beat on the result channel, as the checker sees it.
   typedef struct packed {
      logic [7:0] data;
      logic       rep;
      logic       fin;
   } san_beat_type;

   // One row of the directed table. Where known is set, the single result beat of
   // that byte is typed into the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [7:0] data;
      logic       fin;
      logic       known;
      logic [7:0] want_data;
      logic       want_rep;
   } stim_row_type;

   localparam int N_DIRECTED = 26;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // Extremes of ASCII, then every kind of bad start byte, one ending a string.
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},
      '{8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},
      '{8'h80, 1'b0, 1'b1, u8s_pkg::QMARK, 1'b1},
      '{8'hBF, 1'b0, 1'b1, u8s_pkg::QMARK, 1'b1},
      '{8'hF8, 1'b0, 1'b1, u8s_pkg::QMARK, 1'b1},
      '{8'hFF, 1'b1, 1'b1, u8s_pkg::QMARK, 1'b1},
      // Well-formed two, three and four byte sequences; the last one ends the string
      // on its final continuation, so it has to come out whole.
      '{8'hC2, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hA9, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h82, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hAC, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h9F, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h98, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h80, 1'b1, 1'b0, 8'h00, 1'b0},
      // Three held bytes broken by ASCII: four beats from one byte.
      '{8'hF4, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h8F, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hBF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h41, 1'b0, 1'b0, 8'h00, 1'b0},
      // A lead broken by another lead, which then completes.
      '{8'hE0, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
      // A lone lead at end of string is flushed as a single replacement.
      '{8'hF7, 1'b1, 1'b1, u8s_pkg::QMARK, 1'b1},
      // A lead broken by a lead that is itself flushed at end of string.
      '{8'hDF, 1'b0, 1'b0, 8'h00, 1'b0},
      '{8'hF0, 1'b1, 1'b0, 8'h00, 1'b0},
      '{8'h20, 1'b1, 1'b1, 8'h20, 1'b0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   u8s_req_if req_bus ();
   u8s_rsp_if rsp_bus ();

   utf8_sanitizer_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #4 clock = ~clock;

   // Result beats still owed by the block, oldest first.
   san_beat_type out_expected[$];
   // Beats that the predictor works out for the byte just accepted.
   san_beat_type step_beats[$];

   int  n_errors     = 0;
   int  random_bytes = 0;
   // When set, neither side inserts gaps, so bytes and beats go back to back.
   bit  no_idle      = 1'b0;

   // Predictor state: the open sequence, lead byte first.
   logic [7:0] held_seq [3];
   logic [1:0] need_cnt;
   logic [1:0] held_cnt;

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic void add_beat(input logic [7:0] data, input logic rep);
      san_beat_type nb;
      nb = '{data, rep, 1'b0};
      step_beats.insert(step_beats.size(), nb);
   endfunction

   // Every byte of an open sequence turns into one replacement.
   function automatic void flush_open();
      for (int k = 0; k < held_cnt; k++) add_beat(u8s_pkg::QMARK, 1'b1);
      held_cnt = 2'd0;
      need_cnt = 2'd0;
   endfunction

   // A byte seen with no sequence open: ASCII passes, a lead opens a sequence,
   // anything else is a bad start.
   function automatic void start_fresh(input logic [7:0] b);
      if (b <= ASCII_TOP) begin
         add_beat(b, 1'b0);
         return;
      end
      if ((b & LEAD2_MASK) == LEAD2_TAG) need_cnt = 2'd1;
      else if ((b & LEAD3_MASK) == LEAD3_TAG) need_cnt = 2'd2;
      else if ((b & LEAD4_MASK) == LEAD4_TAG) need_cnt = 2'd3;
      else begin
         add_beat(u8s_pkg::QMARK, 1'b1);
         return;
      end
      held_seq[0] = b;
      held_cnt = 2'd1;
   endfunction

   // Works out the beats one accepted byte causes and leaves them in step_beats.
   function automatic void sanitize_byte(input logic [7:0] b, input logic fin);
      if (held_cnt != 2'd0) begin
         if ((b & CONT_MASK) == CONT_TAG) begin
            // The lead counts as a held byte, so the sequence is complete once
            // the bytes held so far reach the number of continuations it needs.
            if (held_cnt >= need_cnt) begin
               for (int k = 0; k < held_cnt; k++) add_beat(held_seq[k], 1'b0);
               add_beat(b, 1'b0);
               held_cnt = 2'd0;
               need_cnt = 2'd0;
            end else begin
               held_seq[held_cnt] = b;
               held_cnt = held_cnt + 2'd1;
            end
         end else begin
            flush_open();
            start_fresh(b);
         end
      end else begin
         start_fresh(b);
      end
      if (fin) begin
         flush_open();
         if (step_beats.size() > 0) step_beats[step_beats.size() - 1].fin = 1'b1;
      end
   endfunction

   // Offers one byte, waits for its beat, then books the beats it must cause.
   task automatic send_byte(input logic [7:0] b, input logic fin, input logic known,
                            input logic [7:0] want_data, input logic want_rep);
      int gap;
      san_beat_type typed;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      req_bus.in_last <= fin;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      sanitize_byte(b, fin);
      if (known) begin
         // The typed value stands in for what the predictor found.
         step_beats.delete();
         typed = '{want_data, want_rep, fin};
         out_expected.insert(out_expected.size(), typed);
      end else begin
         while (step_beats.size() > 0) begin
            out_expected.insert(out_expected.size(), step_beats.pop_front());
         end
      end
   endtask

   // Holds the input side quiet until every owed beat has come out.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (out_expected.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] make_lead(input int len);
      case (len)
         2: return LEAD2_TAG | 8'($urandom_range(0, 31));
         3: return LEAD3_TAG | 8'($urandom_range(0, 15));
         default: return LEAD4_TAG | 8'($urandom_range(0, 7));
      endcase
   endfunction

   // Builds one string, mostly well-formed characters with random content, with
   // some truncated sequences, stray bytes and noise mixed in, and sends it.
   task automatic send_random_string();
      logic [7:0] text[$];
      int n_chars;
      int kind;
      int len;
      int conts;
      n_chars = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 10);
      for (int c = 0; c < n_chars; c++) begin
         kind = $urandom_range(0, 99);
         if (kind < 35) begin
            text.insert(text.size(), 8'($urandom_range(0, 127)));
         end else if (kind < 74) begin
            len = (kind < 50) ? 2 : (kind < 62) ? 3 : 4;
            text.insert(text.size(), make_lead(len));
            for (int k = 1; k < len; k++) begin
               text.insert(text.size(), CONT_TAG | 8'($urandom_range(0, 63)));
            end
         end else if (kind < 84) begin
            // Lead followed by too few continuations.
            len = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            text.insert(text.size(), make_lead(len));
            for (int k = 0; k < conts; k++) begin
               text.insert(text.size(), CONT_TAG | 8'($urandom_range(0, 63)));
            end
         end else if (kind < 92) begin
            text.insert(text.size(), 8'($urandom_range(0, 255)));
         end else if (kind < 96) begin
            text.insert(text.size(), CONT_TAG | 8'($urandom_range(0, 63)));
         end else begin
            text.insert(text.size(), 8'($urandom_range(8'hF8, 8'hFF)));
         end
      end
      for (int i = 0; i < text.size(); i++) begin
         send_byte(text[i], i == text.size() - 1, 1'b0, 8'h00, 1'b0);
      end
      random_bytes += text.size();
   endtask

   // Result side: ready is redecided every cycle, with random stalls of the same
   // shape as the gaps on the input side.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Checker: values read at the edge are those held during the cycle before it,
   // so a beat is taken exactly when valid and ready were both high.
   always @(posedge clock) begin
      san_beat_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (out_expected.size() == 0) begin
            n_errors++;
            $display("%0t: expected no beat, got byte=%h replaced=%b last=%b", $time,
                     rsp_bus.out_byte, rsp_bus.out_replaced, rsp_bus.out_last);
         end else begin
            want = out_expected.pop_front();
            if (rsp_bus.out_byte !== want.data || rsp_bus.out_replaced !== want.rep ||
                rsp_bus.out_last !== want.fin) begin
               n_errors++;
               $display("%0t: expected %h/%b/%b, got %h/%b/%b (byte/replaced/last)",
                        $time, want.data, want.rep, want.fin, rsp_bus.out_byte,
                        rsp_bus.out_replaced, rsp_bus.out_last);
            end
         end
      end
   end

   // Hard stop far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      req_bus.valid   <= 1'b0;
      req_bus.in_byte <= 8'h00;
      req_bus.in_last <= 1'b0;
      held_seq = '{8'h00, 8'h00, 8'h00};
      need_cnt = 2'd0;
      held_cnt = 2'd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table first, then let everything drain before random traffic.
      for (int i = 0; i < N_DIRECTED; i++) begin
         send_byte(DIRECTED[i].data, DIRECTED[i].fin, DIRECTED[i].known,
                   DIRECTED[i].want_data, DIRECTED[i].want_rep);
      end
      drain_results();

      // Random strings; some run with no gaps at all, and now and then the input
      // side waits for the block to empty completely.
      for (int s = 0; random_bytes < RANDOM_BYTES; s++) begin
         no_idle = ($urandom_range(0, 4) == 0);
         send_random_string();
         if (s % 12 == 11) drain_results();
      end
      no_idle = 1'b0;
      req_bus.valid <= 1'b0;

      while (out_expected.size() != 0) @(posedge clock);
      // Keep watching so that a stray extra beat would still be caught.
      repeat (10) @(posedge clock);

      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
